FILE: src/imu_offset_cal_moving_average_defines.svh
// ----------------------------------------------------------------------------
// imu offset calibration: assertion macros
// shared concurrent property wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef IMU_OFFSET_CAL_MOVING_AVERAGE_DEFINES_SVH
`define IMU_OFFSET_CAL_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imu offset cal: same-cycle property violated");

// next-cycle implication
`define IOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imu offset cal: next-cycle property violated");

`else

`define IOC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define IOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/imu_ofs_pkg.sv
// ----------------------------------------------------------------------------
// imu offset calibration package
// field widths, defaults and types shared by the calibration and window units
// ----------------------------------------------------------------------------
`default_nettype none

package imu_ofs_pkg;

    localparam int RAW_W       = 16;
    localparam int ACC_OFS_W   = 17;
    localparam int GYRO_OFS_W  = 16;
    localparam int ACC_CORR_W  = 18;
    localparam int GYRO_CORR_W = 17;
    localparam int ONE_G_W     = 15;

    localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd4096;

    localparam int WINDOW_DEF      = 8;
    localparam int CAL_SAMPLES_DEF = 512;

    // stream widths
    localparam int S_TDATA_W = 6 * RAW_W;
    localparam int TUSER_W   = 2;
    localparam int M_TDATA_W = 112;
    localparam int ROW_W     = 3 * ACC_CORR_W + 3 * GYRO_CORR_W;

    typedef logic signed [RAW_W-1:0]       t_raw;
    typedef logic signed [ACC_OFS_W-1:0]   t_acc_ofs;
    typedef logic signed [GYRO_OFS_W-1:0]  t_gyro_ofs;
    typedef logic signed [ACC_CORR_W-1:0]  t_acc_corr;
    typedef logic signed [GYRO_CORR_W-1:0] t_gyro_corr;

    typedef t_raw       t_raw_axes       [3];
    typedef t_acc_ofs   t_acc_ofs_axes   [3];
    typedef t_gyro_ofs  t_gyro_ofs_axes  [3];
    typedef t_acc_corr  t_acc_corr_axes  [3];
    typedef t_gyro_corr t_gyro_corr_axes [3];

    // calibration requests, start_acc in bit 0
    typedef struct packed {
        logic start_gyro;
        logic start_acc;
    } t_cal_req;

    // calibration completion, acc_done in bit 0
    typedef struct packed {
        logic gyro_done;
        logic acc_done;
    } t_cal_flags;

endpackage

`default_nettype wire

FILE: src/imu_ofs_ram.sv
// ----------------------------------------------------------------------------
// imu offset calibration: generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module imu_ofs_ram #(
    parameter int WIDTH = imu_ofs_pkg::ROW_W,
    parameter int DEPTH = imu_ofs_pkg::WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/imu_ofs_cdiv.sv
// ----------------------------------------------------------------------------
// imu offset calibration: signed divide by constant
// truncates toward zero; shift for powers of two, reciprocal multiply otherwise
// ----------------------------------------------------------------------------
`default_nettype none

module imu_ofs_cdiv #(
    parameter int WIDTH   = 24,
    parameter int DIVISOR = imu_ofs_pkg::WINDOW_DEF
) (
    input  logic signed [WIDTH-1:0] i_num,
    output logic signed [WIDTH-1:0] o_quo
);

    localparam int Log    = $clog2(DIVISOR);
    localparam bit IsPow2 = (DIVISOR == (1 << Log));

    logic [WIDTH-1:0] mag;
    logic [WIDTH-1:0] q_mag;

    assign mag = i_num[WIDTH-1] ? WIDTH'(-i_num) : WIDTH'(i_num);

    if (IsPow2) begin : g_shift
        assign q_mag = mag >> Log;
    end else begin : g_recip
        // ceil(2^shift / divisor) is exact for every magnitude below 2^width
        localparam int Shift = WIDTH + Log;
        localparam logic [63:0] RecipFull =
            ((64'd1 << Shift) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
        localparam logic [WIDTH:0] Recip = RecipFull[WIDTH:0];

        logic [2*WIDTH:0] prod;

        assign prod  = (2*WIDTH+1)'(mag) * (2*WIDTH+1)'(Recip);
        assign q_mag = WIDTH'(prod >> Shift);
    end

    assign o_quo = i_num[WIDTH-1] ? $signed(-q_mag) : $signed(q_mag);

endmodule

`default_nettype wire

FILE: src/imu_ofs_cal.sv
// ----------------------------------------------------------------------------
// imu offset calibration: offset calibration unit
// accumulates raw samples and turns them into accelerometer and gyro offsets
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_offset_cal_moving_average_defines.svh"

module imu_ofs_cal #(
    parameter int CAL_SAMPLES = imu_ofs_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_fire,
    input  imu_ofs_pkg::t_raw_axes               i_acc,
    input  imu_ofs_pkg::t_raw_axes               i_gyro,
    input  imu_ofs_pkg::t_cal_req                i_req,
    input  logic [imu_ofs_pkg::ONE_G_W-1:0]      i_one_g,
    output imu_ofs_pkg::t_acc_ofs_axes           o_acc_ofs,
    output imu_ofs_pkg::t_gyro_ofs_axes          o_gyro_ofs,
    output imu_ofs_pkg::t_cal_flags              o_flags
);

    import imu_ofs_pkg::*;

    localparam int CntW     = $clog2(CAL_SAMPLES);
    localparam int AccSumW  = ACC_OFS_W + CntW;
    localparam int GyroSumW = RAW_W + CntW;
    localparam logic [CntW-1:0] CntLast = CntW'(CAL_SAMPLES - 1);

    logic                      r_acc_act, r_gyro_act;
    logic [CntW-1:0]           r_acc_cnt, r_gyro_cnt;
    logic signed [AccSumW-1:0]  r_acc_sum  [3];
    logic signed [GyroSumW-1:0] r_gyro_sum [3];
    t_acc_ofs_axes             r_acc_ofs;
    t_gyro_ofs_axes            r_gyro_ofs;

    logic                      n_acc_act, n_gyro_act;
    logic [CntW-1:0]           n_acc_cnt, n_gyro_cnt;
    logic signed [AccSumW-1:0]  n_acc_sum  [3];
    logic signed [GyroSumW-1:0] n_gyro_sum [3];

    logic                      acc_run, acc_last, acc_stay;
    logic                      gyro_run, gyro_last, gyro_stay;
    t_acc_ofs                  acc_in     [3];
    logic signed [AccSumW-1:0]  acc_add    [3];
    logic signed [GyroSumW-1:0] gyro_add   [3];
    logic signed [AccSumW-1:0]  acc_quo    [3];
    logic signed [GyroSumW-1:0] gyro_quo   [3];

    // sums and counters sit at zero while a calibration is idle
    assign acc_run   = r_acc_act | i_req.start_acc;
    assign acc_last  = acc_run && (r_acc_cnt == CntLast);
    assign acc_stay  = acc_run && !acc_last;
    assign gyro_run  = r_gyro_act | i_req.start_gyro;
    assign gyro_last = gyro_run && (r_gyro_cnt == CntLast);
    assign gyro_stay = gyro_run && !gyro_last;

    // one g comes off z before it is accumulated
    assign acc_in[0] = ACC_OFS_W'(i_acc[0]);
    assign acc_in[1] = ACC_OFS_W'(i_acc[1]);
    assign acc_in[2] = ACC_OFS_W'(i_acc[2]) - ACC_OFS_W'(i_one_g);

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign acc_add[a]  = r_acc_sum[a] + AccSumW'(acc_in[a]);
        assign gyro_add[a] = r_gyro_sum[a] + GyroSumW'(i_gyro[a]);

        imu_ofs_cdiv #(
            .WIDTH   (AccSumW),
            .DIVISOR (CAL_SAMPLES)
        ) u_acc_div (
            .i_num (acc_add[a]),
            .o_quo (acc_quo[a])
        );

        imu_ofs_cdiv #(
            .WIDTH   (GyroSumW),
            .DIVISOR (CAL_SAMPLES)
        ) u_gyro_div (
            .i_num (gyro_add[a]),
            .o_quo (gyro_quo[a])
        );

        // offsets finished on this sample already correct it
        assign o_acc_ofs[a]  = acc_last  ? acc_quo[a][ACC_OFS_W-1:0]   : r_acc_ofs[a];
        assign o_gyro_ofs[a] = gyro_last ? gyro_quo[a][GYRO_OFS_W-1:0] : r_gyro_ofs[a];
    end

    always_comb begin
        n_acc_act  = acc_stay;
        n_acc_cnt  = acc_stay ? r_acc_cnt + 1'b1 : '0;
        // a finished accelerometer run hands over to a gyro run
        n_gyro_act = gyro_stay || acc_last;
        n_gyro_cnt = gyro_stay ? r_gyro_cnt + 1'b1 : '0;
        for (int a = 0; a < 3; a++) begin
            n_acc_sum[a]  = acc_stay  ? acc_add[a]  : '0;
            n_gyro_sum[a] = gyro_stay ? gyro_add[a] : '0;
        end
    end

    assign o_flags.acc_done  = acc_last;
    assign o_flags.gyro_done = gyro_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_act  <= 1'b0;
            r_gyro_act <= 1'b0;
            r_acc_cnt  <= '0;
            r_gyro_cnt <= '0;
            for (int a = 0; a < 3; a++) begin
                r_acc_sum[a]  <= '0;
                r_gyro_sum[a] <= '0;
                r_acc_ofs[a]  <= '0;
                r_gyro_ofs[a] <= '0;
            end
        end else if (i_fire) begin
            r_acc_act  <= n_acc_act;
            r_gyro_act <= n_gyro_act;
            r_acc_cnt  <= n_acc_cnt;
            r_gyro_cnt <= n_gyro_cnt;
            r_acc_sum  <= n_acc_sum;
            r_gyro_sum <= n_gyro_sum;
            r_acc_ofs  <= o_acc_ofs;
            r_gyro_ofs <= o_gyro_ofs;
        end
    end

    `IOC_ASSERT_NOW(a_acc_idle_cnt, i_clk, i_rst_n, !r_acc_act, r_acc_cnt == CntW'(0))
    `IOC_ASSERT_NOW(a_gyro_idle_cnt, i_clk, i_rst_n, !r_gyro_act, r_gyro_cnt == CntW'(0))
    `IOC_ASSERT_NXT(a_gyro_follows, i_clk, i_rst_n, i_fire && o_flags.acc_done, r_gyro_act && !r_acc_act)

endmodule

`default_nettype wire

FILE: src/imu_ofs_win.sv
// ----------------------------------------------------------------------------
// imu offset calibration: moving window
// per-axis history in one ram row per slot, with running window sums
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_offset_cal_moving_average_defines.svh"

module imu_ofs_win #(
    parameter int WINDOW = imu_ofs_pkg::WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  imu_ofs_pkg::t_acc_corr_axes      i_acc_corr,
    input  imu_ofs_pkg::t_gyro_corr_axes     i_gyro_corr,
    output logic signed [imu_ofs_pkg::ACC_CORR_W+$clog2(WINDOW)-1:0]  o_acc_sum  [3],
    output logic signed [imu_ofs_pkg::GYRO_CORR_W+$clog2(WINDOW)-1:0] o_gyro_sum [3]
);

    import imu_ofs_pkg::*;

    localparam int PtrW     = $clog2(WINDOW);
    localparam int AccSumW  = ACC_CORR_W + PtrW;
    localparam int GyroSumW = GYRO_CORR_W + PtrW;
    localparam int GyroBase = 3 * ACC_CORR_W;

    logic [PtrW-1:0]            r_ptr;
    logic [WINDOW-1:0]          r_valid;
    logic signed [AccSumW-1:0]  r_acc_sum  [3];
    logic signed [GyroSumW-1:0] r_gyro_sum [3];

    logic signed [AccSumW-1:0]  n_acc_sum  [3];
    logic signed [GyroSumW-1:0] n_gyro_sum [3];
    logic [PtrW-1:0]            n_ptr;

    logic [PtrW-1:0]  raddr;
    logic [ROW_W-1:0] rd_row, old_row, new_row;
    t_acc_corr        old_acc  [3];
    t_gyro_corr       old_gyro [3];

    assign n_ptr = (r_ptr == PtrW'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;

    // read ahead so the row under the pointer is ready when the item arrives
    assign raddr = i_advance ? n_ptr : r_ptr;

    // rows not yet written count as zero
    assign old_row = r_valid[r_ptr] ? rd_row : '0;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign old_acc[a]  = old_row[a*ACC_CORR_W +: ACC_CORR_W];
        assign old_gyro[a] = old_row[GyroBase + a*GYRO_CORR_W +: GYRO_CORR_W];
        assign new_row[a*ACC_CORR_W +: ACC_CORR_W]              = i_acc_corr[a];
        assign new_row[GyroBase + a*GYRO_CORR_W +: GYRO_CORR_W] = i_gyro_corr[a];

        assign n_acc_sum[a]  = r_acc_sum[a] + AccSumW'(i_acc_corr[a])
                             - AccSumW'(old_acc[a]);
        assign n_gyro_sum[a] = r_gyro_sum[a] + GyroSumW'(i_gyro_corr[a])
                             - GyroSumW'(old_gyro[a]);
    end

    imu_ofs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_advance),
        .i_waddr (r_ptr),
        .i_wdata (new_row),
        .i_raddr (raddr),
        .o_rdata (rd_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_valid <= '0;
            for (int a = 0; a < 3; a++) begin
                r_acc_sum[a]  <= '0;
                r_gyro_sum[a] <= '0;
            end
        end else if (i_advance) begin
            r_ptr          <= n_ptr;
            r_valid[r_ptr] <= 1'b1;
            r_acc_sum      <= n_acc_sum;
            r_gyro_sum     <= n_gyro_sum;
        end
    end

    assign o_acc_sum  = r_acc_sum;
    assign o_gyro_sum = r_gyro_sum;

    // slots fill in pointer order, so a valid slot under the pointer means all are
    `IOC_ASSERT_NOW(a_fill_order, i_clk, i_rst_n, r_valid[r_ptr], &r_valid)
    `IOC_ASSERT_NXT(a_valid_grows, i_clk, i_rst_n, 1'b1, $countones(r_valid) >= $past($countones(r_valid)))

endmodule

`default_nettype wire

FILE: src/imu_offset_cal_moving_average.sv
// ----------------------------------------------------------------------------
// imu offset calibration with moving average
// six-axis bias removal, on-demand offset calibration and per-axis window mean
// ----------------------------------------------------------------------------
// Takes one six-axis sample per transaction and returns one result per
// sample. A sample is registered; when it fires, it updates the offset
// calibration, is corrected by the current offsets and enters the WINDOW-deep
// history; the middle stage then divides the registered window sums by WINDOW
// into the output register. Throughput is one sample per clock while the
// output is not stalled, limited by the combinational state update
// (accumulator add, offset divide, offset subtract and window sum update).
// The window history lives in one ram row per slot with a valid bit per row,
// so the block is ready right after reset with no clearing pass; unwritten
// slots count as zero. Averages and offsets truncate toward zero.
// one_g_counts must be written over the cfg channel only while the block is
// idle, which the block itself does not enforce; its reset value is 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_offset_cal_moving_average #(
    parameter int WINDOW      = imu_ofs_pkg::WINDOW_DEF,
    parameter int CAL_SAMPLES = imu_ofs_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // sample input
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z (16 bit each)
    input  logic [imu_ofs_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // start_acc_cal, start_gyro_cal
    input  logic [imu_ofs_pkg::TUSER_W-1:0]      i_s_axis_tuser,

    // averaged output
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // avg_acc_x, avg_acc_y, avg_acc_z (18 bit), avg_gyro_x, avg_gyro_y,
    // avg_gyro_z (17 bit), zero pad
    output logic [imu_ofs_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // acc_cal_done, gyro_cal_done
    output logic [imu_ofs_pkg::TUSER_W-1:0]      o_m_axis_tuser,

    // one_g_counts register write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [imu_ofs_pkg::ONE_G_W-1:0]      i_cfg_data
);

    import imu_ofs_pkg::*;

    localparam int AccSumW  = ACC_CORR_W + $clog2(WINDOW);
    localparam int GyroSumW = GYRO_CORR_W + $clog2(WINDOW);
    localparam int PadW     = M_TDATA_W - ROW_W;

    // pipeline control
    logic r_in_v, r_mid_v, r_out_v;
    logic n_in_v, n_mid_v, n_out_v;
    logic out_free, mid_adv, mid_free, fire, in_acc;

    // input register
    t_raw_axes  r_in_acc, r_in_gyro;
    t_cal_req   r_in_req;

    // config register
    logic [ONE_G_W-1:0] r_one_g;

    // state update path
    t_acc_ofs_axes   acc_ofs;
    t_gyro_ofs_axes  gyro_ofs;
    t_cal_flags      cal_flags;
    t_acc_corr_axes  acc_corr;
    t_gyro_corr_axes gyro_corr;
    logic signed [AccSumW-1:0]  acc_sum  [3];
    logic signed [GyroSumW-1:0] gyro_sum [3];

    // completion flags that travel with the window sums
    t_cal_flags r_mid_flags;

    // average path and output register
    logic signed [AccSumW-1:0]  acc_quo  [3];
    logic signed [GyroSumW-1:0] gyro_quo [3];
    t_acc_corr   r_out_acc  [3];
    t_gyro_corr  r_out_gyro [3];
    t_cal_flags  r_out_flags;

    // each stage moves when the one after it is empty or emptying
    assign out_free = !r_out_v || i_m_axis_tready;
    assign mid_adv  = r_mid_v && out_free;
    assign mid_free = !r_mid_v || out_free;
    assign fire     = r_in_v && mid_free;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_in_v || fire;

    always_comb begin
        n_in_v  = in_acc  ? 1'b1 : (fire    ? 1'b0 : r_in_v);
        n_mid_v = fire    ? 1'b1 : (mid_adv ? 1'b0 : r_mid_v);
        n_out_v = mid_adv ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_out_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
            r_one_g <= ONE_G_RESET;
        end else begin
            r_in_v  <= n_in_v;
            r_mid_v <= n_mid_v;
            r_out_v <= n_out_v;
            if (i_cfg_valid) begin
                r_one_g <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // input register, unpacked from the stream word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int a = 0; a < 3; a++) begin
                r_in_acc[a]  <= i_s_axis_tdata[a*RAW_W +: RAW_W];
                r_in_gyro[a] <= i_s_axis_tdata[(a+3)*RAW_W +: RAW_W];
            end
            r_in_req <= t_cal_req'(i_s_axis_tuser);
        end
    end

    // calibration runs first so finishing offsets apply to this sample
    imu_ofs_cal #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_cal (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_acc      (r_in_acc),
        .i_gyro     (r_in_gyro),
        .i_req      (r_in_req),
        .i_one_g    (r_one_g),
        .o_acc_ofs  (acc_ofs),
        .o_gyro_ofs (gyro_ofs),
        .o_flags    (cal_flags)
    );

    // offset correction, widened so it never wraps
    for (genvar a = 0; a < 3; a++) begin : g_corr
        assign acc_corr[a]  = ACC_CORR_W'(r_in_acc[a]) - ACC_CORR_W'(acc_ofs[a]);
        assign gyro_corr[a] = GYRO_CORR_W'(r_in_gyro[a]) - GYRO_CORR_W'(gyro_ofs[a]);
    end

    // window sums update on fire and then hold the middle stage's data
    imu_ofs_win #(
        .WINDOW (WINDOW)
    ) u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (fire),
        .i_acc_corr  (acc_corr),
        .i_gyro_corr (gyro_corr),
        .o_acc_sum   (acc_sum),
        .o_gyro_sum  (gyro_sum)
    );

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_mid_flags <= cal_flags;
        end
    end

    // window mean, truncated toward zero
    for (genvar a = 0; a < 3; a++) begin : g_avg
        imu_ofs_cdiv #(
            .WIDTH   (AccSumW),
            .DIVISOR (WINDOW)
        ) u_acc_avg (
            .i_num (acc_sum[a]),
            .o_quo (acc_quo[a])
        );

        imu_ofs_cdiv #(
            .WIDTH   (GyroSumW),
            .DIVISOR (WINDOW)
        ) u_gyro_avg (
            .i_num (gyro_sum[a]),
            .o_quo (gyro_quo[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (mid_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_out_acc[a]  <= acc_quo[a][ACC_CORR_W-1:0];
                r_out_gyro[a] <= gyro_quo[a][GYRO_CORR_W-1:0];
            end
            r_out_flags <= r_mid_flags;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {PadW'(0),
                              r_out_gyro[2], r_out_gyro[1], r_out_gyro[0],
                              r_out_acc[2],  r_out_acc[1],  r_out_acc[0]};
    assign o_m_axis_tuser  = r_out_flags;

endmodule

`default_nettype wire
